/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the core's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_AT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// House form: clk and arst_n of the enclosing module.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

/* hw/rtl/cpu16_pkg.sv */
package cpu16_pkg;

	// item functions
	localparam logic [2:0] FN_WMEM = 3'd0;
	localparam logic [2:0] FN_RMEM = 3'd1;
	localparam logic [2:0] FN_EXEC = 3'd2;
	localparam logic [2:0] FN_RREG = 3'd3;
	localparam logic [2:0] FN_WREG = 3'd4;

	// register selects above the general registers
	localparam logic [15:0] RS_PC = 16'd8;
	localparam logic [15:0] RS_SP = 16'd9;
	localparam logic [15:0] RS_EX = 16'd10;
	localparam logic [15:0] RS_IA = 16'd11;

	localparam logic [2:0] REG_I = 3'd6;
	localparam logic [2:0] REG_J = 3'd7;

	// basic opcodes
	localparam logic [4:0] OP_SPECIAL = 5'h00;
	localparam logic [4:0] OP_SET = 5'h01;
	localparam logic [4:0] OP_ADD = 5'h02;
	localparam logic [4:0] OP_SUB = 5'h03;
	localparam logic [4:0] OP_MUL = 5'h04;
	localparam logic [4:0] OP_MLI = 5'h05;
	localparam logic [4:0] OP_DIV = 5'h06;
	localparam logic [4:0] OP_DVI = 5'h07;
	localparam logic [4:0] OP_MOD = 5'h08;
	localparam logic [4:0] OP_MDI = 5'h09;
	localparam logic [4:0] OP_AND = 5'h0a;
	localparam logic [4:0] OP_BOR = 5'h0b;
	localparam logic [4:0] OP_XOR = 5'h0c;
	localparam logic [4:0] OP_SHR = 5'h0d;
	localparam logic [4:0] OP_ASR = 5'h0e;
	localparam logic [4:0] OP_SHL = 5'h0f;
	localparam logic [4:0] OP_IFB = 5'h10;
	localparam logic [4:0] OP_IFC = 5'h11;
	localparam logic [4:0] OP_IFE = 5'h12;
	localparam logic [4:0] OP_IFN = 5'h13;
	localparam logic [4:0] OP_IFG = 5'h14;
	localparam logic [4:0] OP_IFA = 5'h15;
	localparam logic [4:0] OP_IFL = 5'h16;
	localparam logic [4:0] OP_IFU = 5'h17;
	localparam logic [4:0] OP_ADX = 5'h1a;
	localparam logic [4:0] OP_SBX = 5'h1b;
	localparam logic [4:0] OP_STI = 5'h1e;
	localparam logic [4:0] OP_STD = 5'h1f;

	// special opcodes (b field when opcode is zero)
	localparam logic [4:0] SOP_JSR = 5'h01;
	localparam logic [4:0] SOP_INT = 5'h08;
	localparam logic [4:0] SOP_IAG = 5'h09;
	localparam logic [4:0] SOP_IAS = 5'h0a;

	// operand modes
	localparam logic [5:0] MODE_IND = 6'h08;
	localparam logic [5:0] MODE_IDX = 6'h10;
	localparam logic [5:0] MODE_STK = 6'h18;
	localparam logic [5:0] MODE_PEEK = 6'h19;
	localparam logic [5:0] MODE_PICK = 6'h1a;
	localparam logic [5:0] MODE_SP = 6'h1b;
	localparam logic [5:0] MODE_PC = 6'h1c;
	localparam logic [5:0] MODE_EX = 6'h1d;
	localparam logic [5:0] MODE_NWIND = 6'h1e;
	localparam logic [5:0] MODE_NWLIT = 6'h1f;
	localparam logic [15:0] LIT_BIAS = 16'h0021;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [15:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic        wr;
		logic [15:0] res;
		logic        ex_wr;
		logic [15:0] ex_val;
		logic        cond;
		logic        undef;
		logic        is_div;
	} alu_res_t;

	// operand modes that take a word after the instruction
	function automatic logic has_next_word(input logic [5:0] mode);
		return (mode >= MODE_IDX && mode < MODE_STK) || mode == MODE_PICK ||
			mode == MODE_NWIND || mode == MODE_NWLIT;
	endfunction

	// length in words of an instruction, for skipping
	function automatic logic [15:0] inst_len(input logic [15:0] w);
		logic [1:0] len;
		len = 2'd1 + {1'b0, has_next_word(w[15:10])};
		if (w[4:0] != OP_SPECIAL && has_next_word({1'b0, w[9:5]}))
			len = len + 2'd1;
		return {14'h0, len};
	endfunction

endpackage

/* hw/rtl/cpu16_ram.sv */
module cpu16_ram #(
	parameter int AW = 16,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

/* hw/rtl/cpu16_div.sv */
`include "assert_macros.svh"

module cpu16_div import cpu16_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] rem_hi_q;
	logic [15:0] divisor_q;
	logic [31:0] quot_q;

	logic [16:0] rem_sh;
	logic [17:0] diff;
	logic        ge;
	logic [15:0] rem_next;

	// one restoring step: shift in next dividend bit, try subtract
	assign rem_sh   = {rem_q, quot_q[31]};
	assign diff     = {1'b0, rem_sh} - {2'b00, divisor_q};
	assign ge       = !diff[17];
	assign rem_next = ge ? diff[15:0] : rem_sh[15:0];

	// dividend {b, 16'h0}: quotient high half is b/a, low half the fraction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q    <= 1'b1;
				cnt_q     <= '0;
				rem_q     <= '0;
				quot_q    <= {req.dividend, 16'h0};
				divisor_q <= req.divisor;
			end else if (busy_q) begin
				rem_q  <= rem_next;
				quot_q <= {quot_q[30:0], ge};
				cnt_q  <= cnt_q + 5'd1;
				// remainder of b/a once all bits of b are in
				if (cnt_q == 5'd15)
					rem_hi_q <= rem_next;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_hi_q;

	`ASSERT_STD(a_no_restart, req.start |-> !busy_q, "divider started while busy")
	`ASSERT_STD(a_done_idle, done_q |-> !busy_q && $past(busy_q), "done without a run")

endmodule

/* hw/rtl/cpu16_alu.sv */
module cpu16_alu import cpu16_pkg::*; (
	input  logic [4:0]  op,
	input  logic [15:0] av,
	input  logic [15:0] bv,
	input  logic [15:0] ex,
	output alu_res_t    res
);

	logic [16:0]        sum17;
	logic [17:0]        adx18;
	logic [18:0]        sbx19;
	logic [31:0]        prod_u;
	logic signed [31:0] prod_s;
	logic [31:0]        shr32;
	logic [31:0]        shl32;
	logic [15:0]        asr16;

	assign sum17  = {1'b0, bv} + {1'b0, av};
	assign adx18  = {2'b00, bv} + {2'b00, av} + {2'b00, ex};
	assign sbx19  = {3'b000, bv} - {3'b000, av} + {3'b000, ex};
	assign prod_u = bv * av;
	assign prod_s = $signed(bv) * $signed(av);
	// counts of 32 and more clear everything; asr16 is all ones from a count of 16
	assign shr32  = (|av[15:5]) ? 32'h0 : ({bv, 16'h0} >> av[4:0]);
	assign shl32  = (|av[15:5]) ? 32'h0 : ({16'h0, bv} << av[4:0]);
	assign asr16  = (|av[15:4]) ? 16'hffff : ~((~bv) >> av[3:0]);

	always_comb begin
		res        = '0;
		res.cond   = 1'b1;
		case (op) inside
			OP_SET, OP_STI, OP_STD: begin
				res.wr  = 1'b1;
				res.res = av;
			end
			OP_ADD: begin
				res.wr     = 1'b1;
				res.res    = sum17[15:0];
				res.ex_wr  = 1'b1;
				res.ex_val = {15'h0, sum17[16]};
			end
			OP_SUB: begin
				res.wr     = 1'b1;
				res.res    = bv - av;
				res.ex_wr  = 1'b1;
				res.ex_val = (bv < av) ? 16'hffff : 16'h0;
			end
			OP_MUL: begin
				res.wr     = 1'b1;
				res.res    = prod_u[15:0];
				res.ex_wr  = 1'b1;
				res.ex_val = prod_u[31:16];
			end
			OP_MLI: begin
				res.wr     = 1'b1;
				res.res    = prod_s[15:0];
				res.ex_wr  = 1'b1;
				res.ex_val = prod_s[31:16];
			end
			OP_DIV, OP_DVI, OP_MOD, OP_MDI: res.is_div = 1'b1;
			OP_AND: begin
				res.wr  = 1'b1;
				res.res = bv & av;
			end
			OP_BOR: begin
				res.wr  = 1'b1;
				res.res = bv | av;
			end
			OP_XOR: begin
				res.wr  = 1'b1;
				res.res = bv ^ av;
			end
			OP_SHR, OP_ASR: begin
				res.wr     = 1'b1;
				res.res    = (op == OP_ASR && bv[15]) ? asr16 : shr32[31:16];
				res.ex_wr  = 1'b1;
				res.ex_val = shr32[15:0];
			end
			OP_SHL: begin
				res.wr     = 1'b1;
				res.res    = shl32[15:0];
				res.ex_wr  = 1'b1;
				res.ex_val = shl32[31:16];
			end
			OP_IFB: res.cond = (bv & av) != 16'h0;
			OP_IFC: res.cond = (bv & av) == 16'h0;
			OP_IFE: res.cond = bv == av;
			OP_IFN: res.cond = bv != av;
			OP_IFG: res.cond = bv > av;
			OP_IFA: res.cond = $signed(bv) > $signed(av);
			OP_IFL: res.cond = bv < av;
			OP_IFU: res.cond = $signed(bv) < $signed(av);
			OP_ADX: begin
				res.wr     = 1'b1;
				res.res    = adx18[15:0];
				res.ex_wr  = 1'b1;
				res.ex_val = {15'h0, |adx18[17:16]};
			end
			OP_SBX: begin
				res.wr     = 1'b1;
				res.res    = sbx19[15:0];
				res.ex_wr  = 1'b1;
				res.ex_val = sbx19[18] ? 16'hffff : {15'h0, |sbx19[17:16]};
			end
			default: res.undef = 1'b1;
		endcase
	end

endmodule

/* hw/rtl/sixteen_bit_cpu_core.sv */
// Channel   Handshake               Payload
// cmd       cmd_valid / cmd_ready   func, address, data
// res       res_valid / res_ready   read_data, pc_now, ex_now, cond_failed, undefined_op
//
// After reset a clearing pass zeroes the 65536-word memory, one word a cycle;
// cmd_ready stays low until the pass is done.
// Items step through the sequencer states; an instruction's fetch, next words
// and operand reads each take a turn on the single memory port, STI and STD add
// an index step, a division waits on the bit-serial divider and each skipped
// instruction is read through the port. One item is in work at a time; a finished
// result waits in the output register while the next item is taken.
`include "assert_macros.svh"

module sixteen_bit_cpu_core import cpu16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  func,
	input  logic [15:0] address,
	input  logic [15:0] data,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [15:0] read_data,
	output logic [15:0] pc_now,
	output logic [15:0] ex_now,
	output logic        cond_failed,
	output logic        undefined_op
);

	typedef enum logic [15:0] {
		S_CLEAR = 16'h0001,
		S_IDLE  = 16'h0002,
		S_MRD   = 16'h0004,
		S_FETCH = 16'h0008,
		S_INST  = 16'h0010,
		S_DEC   = 16'h0020,
		S_NW    = 16'h0040,
		S_READ  = 16'h0080,
		S_RVAL  = 16'h0100,
		S_SPEC  = 16'h0200,
		S_EXEC  = 16'h0400,
		S_DIVW  = 16'h0800,
		S_STEP  = 16'h1000,
		S_SKIP  = 16'h2000,
		S_SKIPW = 16'h4000,
		S_DONE  = 16'h8000
	} state_t;

	typedef enum logic [2:0] {
		LOC_REG,
		LOC_MEM,
		LOC_SP,
		LOC_PC,
		LOC_EX,
		LOC_LIT
	} loc_kind_t;

	state_t      state_q;
	logic [15:0] clr_cnt_q;
	logic [15:0] skip_cnt_q;

	// architectural state
	logic [15:0] regs_q [8];
	logic [15:0] pc_q;
	logic [15:0] sp_q;
	logic [15:0] ex_q;
	logic [15:0] ia_q;

	// instruction in work
	logic [15:0] inst_q;
	logic [5:0]  mode_q;
	logic        is_a_q;
	loc_kind_t   cur_kind_q;
	logic [15:0] cur_where_q;
	loc_kind_t   la_kind_q;
	logic [15:0] la_where_q;
	logic [15:0] av_q;
	loc_kind_t   lb_kind_q;
	logic [15:0] lb_where_q;
	logic [15:0] bv_q;
	logic [15:0] rd_q;
	logic        cond_q;
	logic        undef_q;

	// output register
	logic        res_valid_q;
	logic [15:0] res_rd_q;
	logic [15:0] res_pc_q;
	logic [15:0] res_ex_q;
	logic        res_cond_q;
	logic        res_undef_q;

	logic [4:0]  op;
	logic [4:0]  bmode;
	logic [5:0]  amode;
	assign op    = inst_q[4:0];
	assign bmode = inst_q[9:5];
	assign amode = inst_q[15:10];

	logic        ram_we;
	logic [15:0] ram_addr;
	logic [15:0] ram_wdata;
	logic [15:0] ram_rdata;

	cpu16_ram #(.AW(16), .DW(16)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	alu_res_t alu;
	cpu16_alu u_alu (
		.op  (op),
		.av  (av_q),
		.bv  (bv_q),
		.ex  (ex_q),
		.res (alu)
	);

	// divider operands: magnitudes for the signed forms
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     signed_div;
	logic     q_neg;
	logic     r_neg;

	assign signed_div       = (op == OP_DVI) || (op == OP_MDI);
	assign q_neg            = bv_q[15] ^ av_q[15];
	assign r_neg            = bv_q[15];
	assign div_req.start    = (state_q == S_EXEC) && alu.is_div && (av_q != 16'h0);
	assign div_req.dividend = (signed_div && bv_q[15]) ? (16'h0 - bv_q) : bv_q;
	assign div_req.divisor  = (signed_div && av_q[15]) ? (16'h0 - av_q) : av_q;

	cpu16_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// division results with signs restored
	logic [15:0] div_b;
	logic [15:0] div_ex;
	logic        div_sets_ex;
	assign div_sets_ex = (op == OP_DIV) || (op == OP_DVI);

	always_comb begin
		div_b  = div_rsp.quot[31:16];
		div_ex = div_rsp.quot[15:0];
		case (op) inside
			OP_DVI: begin
				div_b  = q_neg ? (16'h0 - div_rsp.quot[31:16]) : div_rsp.quot[31:16];
				div_ex = q_neg ? (16'h0 - div_rsp.quot[15:0]) : div_rsp.quot[15:0];
			end
			OP_MOD: div_b = div_rsp.rem;
			OP_MDI: div_b = r_neg ? (16'h0 - div_rsp.rem) : div_rsp.rem;
			default: ;
		endcase
	end

	// read mux on the general registers, for the read-register item and operands
	logic [2:0]  reg_idx;
	logic [15:0] reg_rd;
	always_comb begin
		unique case (state_q)
			S_IDLE:  reg_idx = address[2:0];
			S_RVAL:  reg_idx = cur_where_q[2:0];
			default: reg_idx = mode_q[2:0];
		endcase
	end
	assign reg_rd = regs_q[reg_idx];

	// register select read for the read-register item
	logic [15:0] sel_rd;
	always_comb begin
		if (address < 16'd8)
			sel_rd = reg_rd;
		else if (address == RS_PC)
			sel_rd = pc_q;
		else if (address == RS_SP)
			sel_rd = sp_q;
		else if (address == RS_EX)
			sel_rd = ex_q;
		else if (address == RS_IA)
			sel_rd = ia_q;
		else
			sel_rd = 16'h0;
	end

	// operand value once its location is known
	logic [15:0] loc_val;
	always_comb begin
		case (cur_kind_q)
			LOC_REG: loc_val = reg_rd;
			LOC_MEM: loc_val = ram_rdata;
			LOC_SP:  loc_val = sp_q;
			LOC_PC:  loc_val = pc_q;
			LOC_EX:  loc_val = ex_q;
			default: loc_val = cur_where_q;
		endcase
	end

	// destination write and EX update; EX update wins
	logic        wr_en;
	loc_kind_t   wr_kind;
	logic [15:0] wr_where;
	logic [15:0] wr_val;
	logic        ex_set;
	logic [15:0] ex_val;

	always_comb begin
		wr_en    = 1'b0;
		wr_kind  = lb_kind_q;
		wr_where = lb_where_q;
		wr_val   = alu.res;
		ex_set   = 1'b0;
		ex_val   = alu.ex_val;
		if (state_q == S_SPEC && bmode == SOP_IAG) begin
			wr_en    = 1'b1;
			wr_kind  = la_kind_q;
			wr_where = la_where_q;
			wr_val   = ia_q;
		end else if (state_q == S_EXEC) begin
			if (alu.is_div && av_q == 16'h0) begin
				wr_en  = 1'b1;
				wr_val = 16'h0;
				ex_set = div_sets_ex;
				ex_val = 16'h0;
			end else if (alu.wr) begin
				wr_en  = 1'b1;
				ex_set = alu.ex_wr;
			end
		end else if (state_q == S_DIVW && div_rsp.done) begin
			wr_en  = 1'b1;
			wr_val = div_b;
			ex_set = div_sets_ex;
			ex_val = div_ex;
		end
	end

	// memory port
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pc_q;
		ram_wdata = 16'h0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_cnt_q;
			end
			S_IDLE: begin
				ram_we    = cmd_valid && (func == FN_WMEM);
				ram_addr  = address;
				ram_wdata = data;
			end
			S_READ: ram_addr = cur_where_q;
			S_SPEC: begin
				if (bmode == SOP_JSR) begin
					ram_we    = 1'b1;
					ram_addr  = sp_q - 16'd1;
					ram_wdata = pc_q;
				end
			end
			default: ;
		endcase
		if (wr_en && wr_kind == LOC_MEM) begin
			ram_we    = 1'b1;
			ram_addr  = wr_where;
			ram_wdata = wr_val;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			skip_cnt_q  <= '0;
			regs_q      <= '{default: '0};
			pc_q        <= '0;
			sp_q        <= '0;
			ex_q        <= '0;
			ia_q        <= '0;
			rd_q        <= '0;
			cond_q      <= 1'b0;
			undef_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && state_q != S_DONE)
				res_valid_q <= 1'b0;

			if (wr_en) begin
				case (wr_kind)
					LOC_REG: regs_q[wr_where[2:0]] <= wr_val;
					LOC_SP:  sp_q <= wr_val;
					LOC_PC:  pc_q <= wr_val;
					LOC_EX: begin
						if (!ex_set)
							ex_q <= wr_val;
					end
					default: ;
				endcase
			end
			if (ex_set)
				ex_q <= ex_val;

			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 16'd1;
					if (clr_cnt_q == 16'hffff)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						rd_q    <= 16'h0;
						cond_q  <= 1'b0;
						undef_q <= 1'b0;
						state_q <= S_DONE;
						case (func)
							FN_RMEM: state_q <= S_MRD;
							FN_EXEC: state_q <= S_FETCH;
							FN_RREG: rd_q <= sel_rd;
							FN_WREG: begin
								if (address < 16'd8)
									regs_q[address[2:0]] <= data;
								else if (address == RS_PC)
									pc_q <= data;
								else if (address == RS_SP)
									sp_q <= data;
								else if (address == RS_EX)
									ex_q <= data;
								else if (address == RS_IA)
									ia_q <= data;
							end
							default: ;
						endcase
					end
				end
				S_MRD: begin
					rd_q    <= ram_rdata;
					state_q <= S_DONE;
				end
				S_FETCH: begin
					pc_q    <= pc_q + 16'd1;
					state_q <= S_INST;
				end
				S_INST: begin
					inst_q  <= ram_rdata;
					mode_q  <= ram_rdata[15:10];
					is_a_q  <= 1'b1;
					state_q <= S_DEC;
				end
				// operand location; next-word forms go through S_NW
				S_DEC: begin
					state_q    <= S_READ;
					cur_kind_q <= LOC_MEM;
					if (mode_q < MODE_IND) begin
						cur_kind_q  <= LOC_REG;
						cur_where_q <= {10'h0, mode_q};
					end else if (mode_q < MODE_IDX) begin
						cur_where_q <= reg_rd;
					end else if (has_next_word(mode_q)) begin
						pc_q    <= pc_q + 16'd1;
						state_q <= S_NW;
					end else if (mode_q == MODE_STK) begin
						if (is_a_q) begin
							cur_where_q <= sp_q;
							sp_q        <= sp_q + 16'd1;
						end else begin
							cur_where_q <= sp_q - 16'd1;
							sp_q        <= sp_q - 16'd1;
						end
					end else if (mode_q == MODE_PEEK) begin
						cur_where_q <= sp_q;
					end else if (mode_q == MODE_SP) begin
						cur_kind_q <= LOC_SP;
					end else if (mode_q == MODE_PC) begin
						cur_kind_q <= LOC_PC;
					end else if (mode_q == MODE_EX) begin
						cur_kind_q <= LOC_EX;
					end else begin
						cur_kind_q  <= LOC_LIT;
						cur_where_q <= {10'h0, mode_q} - LIT_BIAS;
					end
				end
				S_NW: begin
					cur_kind_q <= (mode_q == MODE_NWLIT) ? LOC_LIT : LOC_MEM;
					if (mode_q < MODE_STK)
						cur_where_q <= reg_rd + ram_rdata;
					else if (mode_q == MODE_PICK)
						cur_where_q <= sp_q + ram_rdata;
					else
						cur_where_q <= ram_rdata;
					state_q <= S_READ;
				end
				S_READ: state_q <= S_RVAL;
				S_RVAL: begin
					if (is_a_q) begin
						av_q       <= loc_val;
						la_kind_q  <= cur_kind_q;
						la_where_q <= cur_where_q;
						if (op == OP_SPECIAL) begin
							state_q <= S_SPEC;
						end else begin
							mode_q  <= {1'b0, bmode};
							is_a_q  <= 1'b0;
							state_q <= S_DEC;
						end
					end else begin
						bv_q       <= loc_val;
						lb_kind_q  <= cur_kind_q;
						lb_where_q <= cur_where_q;
						state_q    <= S_EXEC;
					end
				end
				S_SPEC: begin
					case (bmode)
						SOP_JSR: begin
							sp_q <= sp_q - 16'd1;
							pc_q <= av_q;
						end
						SOP_INT, SOP_IAG: ;
						SOP_IAS: ia_q <= av_q;
						default: undef_q <= 1'b1;
					endcase
					state_q <= S_DONE;
				end
				S_EXEC: begin
					if (alu.undef)
						undef_q <= 1'b1;
					if (div_req.start) begin
						state_q <= S_DIVW;
					end else if (op == OP_STI || op == OP_STD) begin
						state_q <= S_STEP;
					end else if (!alu.cond) begin
						cond_q     <= 1'b1;
						skip_cnt_q <= '0;
						state_q    <= S_SKIP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIVW: begin
					if (div_rsp.done)
						state_q <= S_DONE;
				end
				// index step after the b write has landed
				S_STEP: begin
					if (op == OP_STI) begin
						regs_q[REG_I] <= regs_q[REG_I] + 16'd1;
						regs_q[REG_J] <= regs_q[REG_J] + 16'd1;
					end else begin
						regs_q[REG_I] <= regs_q[REG_I] - 16'd1;
						regs_q[REG_J] <= regs_q[REG_J] - 16'd1;
					end
					state_q <= S_DONE;
				end
				S_SKIP: state_q <= S_SKIPW;
				// skip chain keeps going over conditionals, bounded
				S_SKIPW: begin
					pc_q <= pc_q + inst_len(ram_rdata);
					if (ram_rdata[4:0] >= OP_IFB && ram_rdata[4:0] <= OP_IFU &&
						skip_cnt_q != 16'hffff) begin
						skip_cnt_q <= skip_cnt_q + 16'd1;
						state_q    <= S_SKIP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						res_rd_q    <= rd_q;
						res_pc_q    <= pc_q;
						res_ex_q    <= ex_q;
						res_cond_q  <= cond_q;
						res_undef_q <= undef_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid    = res_valid_q;
	assign read_data    = res_rd_q;
	assign pc_now       = res_pc_q;
	assign ex_now       = res_ex_q;
	assign cond_failed  = res_cond_q;
	assign undefined_op = res_undef_q;

	`ASSERT_STD(a_res_from_done, $rose(res_valid) |-> $past(state_q == S_DONE), "result not from done")
	`ASSERT_STD(a_flags_excl, res_valid |-> !(cond_failed && undefined_op), "both flags set")
	`ASSERT_STD(a_div_nonzero, div_req.start |-> (div_req.divisor != 16'h0), "divide by zero started")

endmodule

/* verif/tb_sixteen_bit_cpu_core.sv */
module tb_sixteen_bit_cpu_core import cpu16_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 320;

	typedef enum logic [2:0] {LK_REG, LK_MEM, LK_SP, LK_PC, LK_EX, LK_LIT} loc_kind_t;

	typedef struct {
		loc_kind_t   kind;
		logic [15:0] where;
	} opnd_t;

	typedef struct {
		logic [2:0]  fn;
		logic [15:0] addr;
		logic [15:0] wdata;
	} cmd_t;

	typedef struct packed {
		logic [15:0] rd;
		logic [15:0] pc;
		logic [15:0] ex;
		logic        cf;
		logic        uo;
	} outcome_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cmd_valid = 0;
	logic        cmd_ready;
	logic [2:0]  func = FN_RMEM;
	logic [15:0] address = '0;
	logic [15:0] data = '0;
	logic        res_valid;
	logic        res_ready = 0;
	logic [15:0] read_data;
	logic [15:0] pc_now;
	logic [15:0] ex_now;
	logic        cond_failed;
	logic        undefined_op;

	sixteen_bit_cpu_core dut (.*);

	// shadow copy of the core's architectural state
	logic [15:0] shadow_mem [65536];
	logic [15:0] gpr [8];
	logic [15:0] pc_m, sp_m, ex_m, ia_m;

	cmd_t     cmd_q [$];
	outcome_t outcome_q [$];
	int       n_errors = 0;
	int       n_sent = 0;
	int       cycles = 0;
	int       send_idle = 0;
	int       recv_stall = 0;
	int       rx_hold = 0;
	bit       cmd_took = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// ---------------- predictor ----------------
	function automatic logic takes_word(input logic [5:0] m);
		return (m >= MODE_IDX && m < MODE_STK) || m == MODE_PICK ||
			m == MODE_NWIND || m == MODE_NWLIT;
	endfunction

	function logic [15:0] next_word();
		next_word = shadow_mem[pc_m];
		pc_m = pc_m + 16'd1;
	endfunction

	function opnd_t decode_opnd(input logic [5:0] m, input bit is_a);
		opnd_t l;
		l.kind = LK_MEM;
		l.where = '0;
		if (m < MODE_IND) begin
			l.kind = LK_REG;
			l.where = {13'd0, m[2:0]};
		end else if (m < MODE_IDX)
			l.where = gpr[m[2:0]];
		else if (m < MODE_STK)
			l.where = gpr[m[2:0]] + next_word();
		else if (m == MODE_STK) begin
			// push for b, pop for a
			if (is_a) begin
				l.where = sp_m;
				sp_m = sp_m + 16'd1;
			end else begin
				sp_m = sp_m - 16'd1;
				l.where = sp_m;
			end
		end else if (m == MODE_PEEK)
			l.where = sp_m;
		else if (m == MODE_PICK)
			l.where = sp_m + next_word();
		else if (m == MODE_SP)
			l.kind = LK_SP;
		else if (m == MODE_PC)
			l.kind = LK_PC;
		else if (m == MODE_EX)
			l.kind = LK_EX;
		else if (m == MODE_NWIND)
			l.where = next_word();
		else if (m == MODE_NWLIT) begin
			l.kind = LK_LIT;
			l.where = next_word();
		end else begin
			l.kind = LK_LIT;
			l.where = {10'd0, m} - LIT_BIAS;
		end
		return l;
	endfunction

	function logic [15:0] read_opnd(input opnd_t l);
		case (l.kind)
			LK_REG: return gpr[l.where[2:0]];
			LK_MEM: return shadow_mem[l.where];
			LK_SP:  return sp_m;
			LK_PC:  return pc_m;
			LK_EX:  return ex_m;
			default: return l.where;
		endcase
	endfunction

	function void write_opnd(input opnd_t l, input logic [15:0] v);
		case (l.kind)
			LK_REG: gpr[l.where[2:0]] = v;
			LK_MEM: shadow_mem[l.where] = v;
			LK_SP:  sp_m = v;
			LK_PC:  pc_m = v;
			LK_EX:  ex_m = v;
			default: ;
		endcase
	endfunction

	// a failed test skips on, through any further tests
	function void skip_tests();
		logic [15:0] w;
		int n;
		for (n = 0; n < 65536; n++) begin
			w = shadow_mem[pc_m];
			pc_m = pc_m + 16'd1 + {15'd0, takes_word(w[15:10])};
			if (w[4:0] != OP_SPECIAL && takes_word({1'b0, w[9:5]}))
				pc_m = pc_m + 16'd1;
			if (w[4:0] < OP_IFB || w[4:0] > OP_IFU)
				break;
		end
	endfunction

	function void exec_insn(output logic cf, output logic uo);
		logic [15:0] inst, av, bv;
		logic [4:0]  o, bm;
		opnd_t       la, lb;
		logic [63:0] t;
		longint      st;
		int          sa, sb, q, sh, s16;
		bit          pass;
		cf = 0;
		uo = 0;
		pass = 1;
		inst = next_word();
		o = inst[4:0];
		bm = inst[9:5];
		la = decode_opnd(inst[15:10], 1);
		av = read_opnd(la);
		if (o == OP_SPECIAL) begin
			case (bm)
				SOP_JSR: begin
					sp_m = sp_m - 16'd1;
					shadow_mem[sp_m] = pc_m;
					pc_m = av;
				end
				SOP_INT: ;
				SOP_IAG: write_opnd(la, ia_m);
				SOP_IAS: ia_m = av;
				default: uo = 1;
			endcase
			return;
		end
		lb = decode_opnd({1'b0, bm}, 0);
		bv = read_opnd(lb);
		sa = $signed(av);
		sb = $signed(bv);
		sh = (av > 16'd48) ? 48 : int'(av);
		case (o)
			OP_SET: write_opnd(lb, av);
			OP_ADD: begin
				t = 64'(bv) + 64'(av);
				write_opnd(lb, t[15:0]);
				ex_m = (t[63:16] != 0) ? 16'd1 : 16'd0;
			end
			OP_SUB: begin
				write_opnd(lb, bv - av);
				ex_m = (bv < av) ? 16'hffff : 16'd0;
			end
			OP_MUL: begin
				t = 64'(bv) * 64'(av);
				write_opnd(lb, t[15:0]);
				ex_m = t[31:16];
			end
			OP_MLI: begin
				st = longint'(sb) * longint'(sa);
				write_opnd(lb, st[15:0]);
				ex_m = st[31:16];
			end
			OP_DIV: begin
				if (av == 0) begin
					write_opnd(lb, 16'd0);
					ex_m = 16'd0;
				end else begin
					write_opnd(lb, bv / av);
					t = (64'(bv) << 16) / 64'(av);
					ex_m = t[15:0];
				end
			end
			OP_DVI: begin
				if (av == 0) begin
					write_opnd(lb, 16'd0);
					ex_m = 16'd0;
				end else begin
					q = sb / sa;
					write_opnd(lb, q[15:0]);
					st = (longint'(sb) * 65536) / longint'(sa);
					ex_m = st[15:0];
				end
			end
			OP_MOD: write_opnd(lb, (av == 0) ? 16'd0 : bv % av);
			OP_MDI: begin
				q = (av == 0) ? 0 : sb % sa;
				write_opnd(lb, q[15:0]);
			end
			OP_AND: write_opnd(lb, bv & av);
			OP_BOR: write_opnd(lb, bv | av);
			OP_XOR: write_opnd(lb, bv ^ av);
			OP_SHR, OP_ASR: begin
				t = (64'(bv) << 16) >> sh;
				if (o == OP_ASR && bv[15]) begin
					s16 = (sh > 16) ? 16 : sh;
					write_opnd(lb, ~((~bv) >> s16));
				end else
					write_opnd(lb, t[31:16]);
				ex_m = t[15:0];
			end
			OP_SHL: begin
				t = 64'(bv) << sh;
				write_opnd(lb, t[15:0]);
				ex_m = t[31:16];
			end
			OP_IFB: pass = (bv & av) != 0;
			OP_IFC: pass = (bv & av) == 0;
			OP_IFE: pass = bv == av;
			OP_IFN: pass = bv != av;
			OP_IFG: pass = bv > av;
			OP_IFA: pass = sb > sa;
			OP_IFL: pass = bv < av;
			OP_IFU: pass = sb < sa;
			OP_ADX: begin
				t = 64'(bv) + 64'(av) + 64'(ex_m);
				write_opnd(lb, t[15:0]);
				ex_m = (t[63:16] != 0) ? 16'd1 : 16'd0;
			end
			OP_SBX: begin
				st = longint'(bv) - longint'(av) + longint'(ex_m);
				write_opnd(lb, st[15:0]);
				ex_m = (st < 0) ? 16'hffff : ((st > 65535) ? 16'd1 : 16'd0);
			end
			OP_STI, OP_STD: begin
				write_opnd(lb, av);
				if (o == OP_STI) begin
					gpr[REG_I] = gpr[REG_I] + 16'd1;
					gpr[REG_J] = gpr[REG_J] + 16'd1;
				end else begin
					gpr[REG_I] = gpr[REG_I] - 16'd1;
					gpr[REG_J] = gpr[REG_J] - 16'd1;
				end
			end
			default: uo = 1;
		endcase
		if (!pass) begin
			cf = 1;
			skip_tests();
		end
	endfunction

	function outcome_t predict_item(input cmd_t c);
		outcome_t r;
		r = '0;
		case (c.fn)
			FN_WMEM: shadow_mem[c.addr] = c.wdata;
			FN_RMEM: r.rd = shadow_mem[c.addr];
			FN_EXEC: exec_insn(r.cf, r.uo);
			FN_RREG: begin
				if (c.addr < 16'd8) r.rd = gpr[c.addr[2:0]];
				else if (c.addr == RS_PC) r.rd = pc_m;
				else if (c.addr == RS_SP) r.rd = sp_m;
				else if (c.addr == RS_EX) r.rd = ex_m;
				else if (c.addr == RS_IA) r.rd = ia_m;
			end
			FN_WREG: begin
				if (c.addr < 16'd8) gpr[c.addr[2:0]] = c.wdata;
				else if (c.addr == RS_PC) pc_m = c.wdata;
				else if (c.addr == RS_SP) sp_m = c.wdata;
				else if (c.addr == RS_EX) ex_m = c.wdata;
				else if (c.addr == RS_IA) ia_m = c.wdata;
			end
			default: ;
		endcase
		r.pc = pc_m;
		r.ex = ex_m;
		return r;
	endfunction

	// ---------------- command side ----------------
	always @(posedge clk) begin
		cmd_took = cmd_valid && cmd_ready;
		if (cmd_took)
			outcome_q.push_back(predict_item('{func, address, data}));
	end

	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_took)) begin
			if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				cmd_t c;
				c = cmd_q.pop_front();
				cmd_valid <= 1'b1;
				func <= c.fn;
				address <= c.addr;
				data <= c.wdata;
			end else
				cmd_valid <= 1'b0;
		end
	end

	// ---------------- result side ----------------
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			res_ready <= 1'b0;
		end else if (arst_n)
			res_ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		outcome_t got, want;
		if (res_valid && res_ready) begin
			got = '{read_data, pc_now, ex_now, cond_failed, undefined_op};
			if (outcome_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result rd=%h pc=%h ex=%h cf=%b uo=%b",
					$time, got.rd, got.pc, got.ex, got.cf, got.uo);
			end else begin
				want = outcome_q.pop_front();
				if (got !== want) begin
					n_errors++;
					$display("%0t: mismatch expected rd=%h pc=%h ex=%h cf=%b uo=%b",
						$time, want.rd, want.pc, want.ex, want.cf, want.uo);
					$display("%0t:          actual   rd=%h pc=%h ex=%h cf=%b uo=%b",
						$time, got.rd, got.pc, got.ex, got.cf, got.uo);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sixteen_bit_cpu_core regression: fail");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	task automatic send(input logic [2:0] f, input logic [15:0] a, input logic [15:0] d);
		cmd_q.push_back('{f, a, d});
		if (f <= FN_WREG)
			n_sent++;
	endtask

	// place up to four words at base, point PC there and run n instructions
	task automatic load_run(input logic [15:0] base, input logic [15:0] w0,
			input logic [15:0] w1, input logic [15:0] w2, input logic [15:0] w3,
			input int nw, input int nexec);
		logic [15:0] w [4];
		w = '{w0, w1, w2, w3};
		for (int i = 0; i < nw; i++)
			send(FN_WMEM, base + 16'(i), w[i]);
		send(FN_WREG, RS_PC, base);
		repeat (nexec) send(FN_EXEC, 16'($urandom), 16'($urandom));
	endtask

	function automatic logic [15:0] insn(input logic [4:0] op, input logic [4:0] b,
			input logic [5:0] a);
		return {a, b, op};
	endfunction

	function automatic logic [15:0] edgy_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000;
			3: return 16'h0001;
			4: return 16'($urandom_range(63));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_insn();
		logic [4:0] spc [4];
		spc = '{SOP_JSR, SOP_INT, SOP_IAG, SOP_IAS};
		if ($urandom_range(4) == 0)
			return insn(OP_SPECIAL, spc[$urandom_range(3)], 6'($urandom));
		return insn(5'($urandom), 5'($urandom), 6'($urandom));
	endfunction

	task automatic rand_prog();
		logic [15:0] w [4];
		int nw;
		// occasional noise: stray reads, writes and unknown functions
		if ($urandom_range(5) == 0) begin
			case ($urandom_range(3))
				0: send(FN_RMEM, 16'($urandom), 16'($urandom));
				1: send(FN_RREG, $urandom_range(3) == 0 ? 16'($urandom) :
					16'($urandom_range(15)), 16'($urandom));
				2: send(FN_WMEM, 16'($urandom), 16'($urandom));
				default: send(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom));
			endcase
		end
		repeat ($urandom_range(2))
			send(FN_WREG, $urandom_range(9) == 0 ? 16'($urandom) :
				16'($urandom_range(11)), edgy_word());
		nw = $urandom_range(1, 4);
		foreach (w[i])
			w[i] = ($urandom_range(2) == 0) ? edgy_word() : rand_insn();
		w[0] = rand_insn();
		load_run(16'($urandom), w[0], w[1], w[2], w[3], nw, $urandom_range(1, 3));
		if ($urandom_range(3) == 0)
			send(FN_RREG, 16'($urandom_range(11)), 16'($urandom));
	endtask

	task automatic drain();
		while (cmd_q.size() > 0 || cmd_valid || outcome_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input bit hold);
		int goal;
		send_idle = idle_pct;
		recv_stall = stall_pct;
		goal = n_sent + PHASE_ITEMS;
		while (n_sent < goal) begin
			rand_prog();
			// long receiver hold-off while commands keep coming
			if (hold && n_sent > goal - PHASE_ITEMS / 2) begin
				hold = 0;
				rx_hold = 400;
			end
			while (cmd_q.size() > 8)
				@(posedge clk);
		end
		drain();
	endtask

	initial begin
		foreach (shadow_mem[i])
			shadow_mem[i] = '0;
		foreach (gpr[i])
			gpr[i] = '0;
		pc_m = '0;
		sp_m = '0;
		ex_m = '0;
		ia_m = '0;
		repeat (5) @(negedge clk);
		arst_n = 1;

		// directed: extremes, unknown functions, out-of-range selects
		send(FN_WMEM, 16'hffff, 16'hffff);
		send(FN_RMEM, 16'hffff, 16'h0000);
		send(FN_RMEM, 16'h0000, 16'hffff);
		send(FN_WREG, RS_IA, 16'hffff);
		send(FN_WREG, 16'd12, 16'h1234);
		send(FN_RREG, RS_IA, '0);
		send(FN_RREG, 16'hffff, '0);
		send(3'd5, 16'hffff, 16'hffff);
		send(3'd7, '0, '0);
		// -32768 / -1 through DVI
		send(FN_WREG, 16'd0, 16'h8000);
		send(FN_WREG, 16'd1, 16'hffff);
		load_run(16'h0100, insn(OP_DVI, 5'd0, 6'd1), 16'd0, 16'd0, 16'd0, 1, 1);
		// divide by literal zero, then a shift beyond the word
		load_run(16'h0110, insn(OP_DIV, 5'd1, 6'h21),
			insn(OP_SHL, 5'd1, MODE_NWLIT), 16'd40, 16'd0, 3, 2);
		// arithmetic shift of a negative value by a large count, EX as target
		send(FN_WREG, 16'd2, 16'h8001);
		load_run(16'h0120, insn(OP_ASR, 5'd2, 6'h3f),
			insn(OP_SHR, MODE_EX[4:0], 6'h30), 16'd0, 16'd0, 2, 2);
		// store into a next-word literal is dropped
		load_run(16'h0130, insn(OP_SET, MODE_NWLIT[4:0], 6'd1), 16'h0aaa, 16'd0, 16'd0,
			2, 1);
		// failed test skips a further test and a two-word instruction
		load_run(16'h0140, insn(OP_IFE, 5'd0, 6'h22), insn(OP_IFG, 5'd1, 6'h21),
			insn(OP_SET, 5'd3, MODE_NWLIT), 16'h5555, 4, 2);
		// STI, unassigned basic and special opcodes, JSR and IA moves
		load_run(16'h0150, insn(OP_STI, 5'h08 + REG_I, 6'd0),
			insn(5'h18, MODE_STK[4:0], MODE_STK), insn(OP_SPECIAL, 5'h1f, 6'd0),
			insn(OP_SPECIAL, SOP_IAS, 6'h3e), 4, 4);
		load_run(16'h0160, insn(OP_SPECIAL, SOP_IAG, 6'd4),
			insn(OP_SPECIAL, SOP_INT, 6'h25), insn(OP_SPECIAL, SOP_JSR, 6'h30),
			16'd0, 3, 3);
		drain();

		run_phase(0, 0, 0);
		run_phase(84, 0, 0);
		run_phase(0, 84, 0);
		run_phase(33, 33, 1);

		if (n_errors == 0)
			$display("sixteen_bit_cpu_core regression: pass");
		else
			$display("sixteen_bit_cpu_core regression: fail");
		$finish;
	end

endmodule
